[hdl/cc20_pkg.sv]
// Shared types, constants and helper functions for the ChaCha20 keystream XOR unit.
// Depends on nothing; imported by every module of the unit.
package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int DWORDS            = 8;
    localparam int BYTES             = 64;

    localparam logic [6:0] MAX_BYTE_COUNT = 7'd64;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_0_7     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_8_15    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_16_23   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_24_31   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_0_7   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_8_11  = 3'd5;

    typedef logic [15:0][31:0] state_t;

    typedef struct packed {
        logic [31:0] block_counter;
        logic [6:0]  byte_count;
        logic [63:0] data_word_0;
        logic [63:0] data_word_1;
        logic [63:0] data_word_2;
        logic [63:0] data_word_3;
        logic [63:0] data_word_4;
        logic [63:0] data_word_5;
        logic [63:0] data_word_6;
        logic [63:0] data_word_7;
    } src_item_t;

    typedef struct packed {
        logic [6:0]  valid_bytes;
        logic [63:0] out_word_0;
        logic [63:0] out_word_1;
        logic [63:0] out_word_2;
        logic [63:0] out_word_3;
        logic [63:0] out_word_4;
        logic [63:0] out_word_5;
        logic [63:0] out_word_6;
        logic [63:0] out_word_7;
    } res_item_t;

    typedef struct packed {
        logic [63:0] key_0_7;
        logic [63:0] key_8_15;
        logic [63:0] key_16_23;
        logic [63:0] key_24_31;
        logic [63:0] nonce_0_7;
        logic [31:0] nonce_8_11;
    } cfg_t;

    // What travels down the round pipeline with each block
    typedef struct packed {
        logic [31:0]               block_counter;
        logic [6:0]                byte_count;   // already saturated
        logic [DWORDS-1:0][63:0]   data;
        state_t                    x;
    } pipe_data_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic state_t init_state(input cfg_t c, input logic [31:0] ctr);
        state_t st;
        st[0]  = SIGMA_0;
        st[1]  = SIGMA_1;
        st[2]  = SIGMA_2;
        st[3]  = SIGMA_3;
        st[4]  = c.key_0_7[31:0];
        st[5]  = c.key_0_7[63:32];
        st[6]  = c.key_8_15[31:0];
        st[7]  = c.key_8_15[63:32];
        st[8]  = c.key_16_23[31:0];
        st[9]  = c.key_16_23[63:32];
        st[10] = c.key_24_31[31:0];
        st[11] = c.key_24_31[63:32];
        st[12] = ctr;
        st[13] = c.nonce_0_7[31:0];
        st[14] = c.nonce_0_7[63:32];
        st[15] = c.nonce_8_11;
        return st;
    endfunction

endpackage

[hdl/cc20_round_stage.sv]
// One pipeline stage: first or second half of four parallel quarter rounds.
// Depends on cc20_pkg.
module cc20_round_stage #(
    parameter bit DIAG   = 1'b0,
    parameter bit SECOND = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  cc20_pkg::pipe_data_t in_data,
    input  logic                down_ready,
    output logic                up_ready,
    output logic                valid,
    output cc20_pkg::pipe_data_t data
);
    import cc20_pkg::*;

    localparam logic [1:0] OFF_B = DIAG ? 2'd1 : 2'd0;
    localparam logic [1:0] OFF_C = DIAG ? 2'd2 : 2'd0;
    localparam logic [1:0] OFF_D = DIAG ? 2'd3 : 2'd0;
    localparam int ROT_1 = SECOND ? 8 : 16;
    localparam int ROT_2 = SECOND ? 7 : 12;

    logic       valid_reg;
    pipe_data_t data_reg;
    pipe_data_t data_next;

    assign up_ready = !valid_reg || down_ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_comb
    begin
        logic [1:0]  col;
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] a, b, c, d;
        data_next = in_data;
        for (int i = 0; i < 4; i++)
        begin
            col = 2'(i);
            ia  = {2'd0, col};
            ib  = {2'd1, col + OFF_B};
            ic  = {2'd2, col + OFF_C};
            id  = {2'd3, col + OFF_D};
            a   = in_data.x[ia];
            b   = in_data.x[ib];
            c   = in_data.x[ic];
            d   = in_data.x[id];
            a   = a + b;
            d   = rotl(d ^ a, ROT_1);
            c   = c + d;
            b   = rotl(b ^ c, ROT_2);
            data_next.x[ia] = a;
            data_next.x[ib] = b;
            data_next.x[ic] = c;
            data_next.x[id] = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/cc20_output_stage.sv]
// Output stage: feed-forward add, keystream XOR, byte masking, result register.
// Depends on cc20_pkg.
module cc20_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  cc20_pkg::pipe_data_t in_data,
    input  cc20_pkg::cfg_t       cfg,
    output logic                 up_ready,
    output logic                 res_valid,
    input  logic                 res_stall,
    output cc20_pkg::res_item_t  res_item
);
    import cc20_pkg::*;

    logic                    res_valid_reg;
    res_item_t               res_item_reg;
    res_item_t               res_item_next;
    state_t                  init;
    logic [DWORDS-1:0][63:0] words;

    assign up_ready  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;
    assign init      = init_state(cfg, in_data.block_counter);

    always_comb
    begin
        logic [63:0] ks;
        for (int k = 0; k < DWORDS; k++)
        begin
            ks = {in_data.x[2*k+1] + init[2*k+1], in_data.x[2*k] + init[2*k]};
            words[k] = in_data.data[k] ^ ks;
            for (int j = 0; j < 8; j++)
            begin
                if (7'(8*k + j) >= in_data.byte_count)
                begin
                    words[k][8*j +: 8] = 8'd0;
                end
            end
        end
    end

    always_comb
    begin
        res_item_next.valid_bytes = in_data.byte_count;
        res_item_next.out_word_0  = words[0];
        res_item_next.out_word_1  = words[1];
        res_item_next.out_word_2  = words[2];
        res_item_next.out_word_3  = words[3];
        res_item_next.out_word_4  = words[4];
        res_item_next.out_word_5  = words[5];
        res_item_next.out_word_6  = words[6];
        res_item_next.out_word_7  = words[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            res_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
        begin
            res_item_reg <= res_item_next;
        end
    end

endmodule

[hdl/chacha20_keystream_xor_unit.sv]
// Path from accepted block to result: input register, round stages, result register.
// Throughput: one 64-byte block per cycle while res_stall is low; each half quarter-round is one register stage.
// Stalls collapse bubbles stage by stage, so src_stall rises only when every stage is full.
// Reset: asynchronous, active low; clears all stage valid bits and zeroes key and nonce.
// Depends on cc20_pkg, cc20_round_stage, cc20_output_stage.
module chacha20_keystream_xor_unit #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // block input channel
    input  logic                               src_valid,
    output logic                               src_stall,
    input  cc20_pkg::src_item_t                src_item,
    // result channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output cc20_pkg::res_item_t                res_item,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cc20_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cc20_pkg::*;

    // Four round stages per double round: column first/second half, diagonal
    // first/second half. Stage 0 is the input register that builds the state.
    localparam int NSTAGES = 4 * DOUBLE_ROUNDS;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    pipe_data_t in_data_reg;
    pipe_data_t in_data_next;

    logic       stage_valid [0:NSTAGES];
    pipe_data_t stage_data  [0:NSTAGES];
    logic       stage_ready [0:NSTAGES+1];  // stage k can load this cycle

    // ---------------------------------------------------------------------
    // Configuration registers. Always ready; the writer must keep writes to idle
    // periods, which the block itself does not enforce, so that the key and nonce
    // are stable while blocks are in flight and need not travel with the data.
    // ---------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_0_7:    cfg_reg.key_0_7    <= cfg_data;
                REG_KEY_8_15:   cfg_reg.key_8_15   <= cfg_data;
                REG_KEY_16_23:  cfg_reg.key_16_23  <= cfg_data;
                REG_KEY_24_31:  cfg_reg.key_24_31  <= cfg_data;
                REG_NONCE_0_7:  cfg_reg.nonce_0_7  <= cfg_data;
                REG_NONCE_8_11: cfg_reg.nonce_8_11 <= cfg_data[31:0];
                default:        ;   // unmapped index: ignored
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input stage: saturate the count, lay out the initial state.
    // ---------------------------------------------------------------------
    always_comb
    begin
        in_data_next.block_counter = src_item.block_counter;
        in_data_next.byte_count    = (src_item.byte_count > MAX_BYTE_COUNT) ?
                                     MAX_BYTE_COUNT : src_item.byte_count;
        in_data_next.data[0]       = src_item.data_word_0;
        in_data_next.data[1]       = src_item.data_word_1;
        in_data_next.data[2]       = src_item.data_word_2;
        in_data_next.data[3]       = src_item.data_word_3;
        in_data_next.data[4]       = src_item.data_word_4;
        in_data_next.data[5]       = src_item.data_word_5;
        in_data_next.data[6]       = src_item.data_word_6;
        in_data_next.data[7]       = src_item.data_word_7;
        in_data_next.x             = init_state(cfg_reg, src_item.block_counter);
    end

    assign stage_ready[0] = !in_valid_reg || stage_ready[1];
    assign src_stall      = !stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stage_ready[0])
        begin
            in_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && src_valid)
        begin
            in_data_reg <= in_data_next;
        end
    end

    assign stage_valid[0] = in_valid_reg;
    assign stage_data[0]  = in_data_reg;

    // ---------------------------------------------------------------------
    // Round pipeline
    // ---------------------------------------------------------------------
    for (genvar k = 1; k <= NSTAGES; k++)
    begin : g_round
        cc20_round_stage #(
            .DIAG   ((((k - 1) / 2) % 2) == 1),
            .SECOND (((k - 1) % 2) == 1)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (stage_valid[k-1]),
            .in_data    (stage_data[k-1]),
            .down_ready (stage_ready[k+1]),
            .up_ready   (stage_ready[k]),
            .valid      (stage_valid[k]),
            .data       (stage_data[k])
        );
    end

    // ---------------------------------------------------------------------
    // Feed-forward, XOR, mask and result register
    // ---------------------------------------------------------------------
    cc20_output_stage u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NSTAGES]),
        .in_data   (stage_data[NSTAGES]),
        .cfg       (cfg_reg),
        .up_ready  (stage_ready[NSTAGES+1]),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // With no result pending, every stage can shift, so input is never held off.
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !src_stall)
        else $error("src_stall high with empty result register");

    // An empty input register always takes a transaction.
    a_input_reg_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !src_stall)
        else $error("src_stall high with empty input register");

    // A block leaving the last round while the result slot is free must show up.
    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[NSTAGES] && !(res_valid && res_stall)) |=> res_valid)
        else $error("block lost between last round and result register");

endmodule

[test/chacha20_keystream_xor_unit_tb.sv]
// Self-checking testbench for chacha20_keystream_xor_unit: random and directed 64-byte blocks
// against a ChaCha20 block predictor, with random source gaps and result-side stalls.
// Depends on cc20_pkg and chacha20_keystream_xor_unit.
module chacha20_keystream_xor_unit_tb;

    import cc20_pkg::*;

    localparam int ROUNDS           = 10;
    // Pipeline depth: four round stages per double round plus input and result registers.
    localparam int LATENCY          = 4 * ROUNDS + 2;
    localparam int FULL_BLOCK_BYTES = 64;
    localparam int MAX_IDLE         = 17;

    // Indexes the unit has no register behind; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

    // "expand 32-byte k", word 0 in the low bits
    localparam logic [127:0] SIGMA_WORDS =
        {32'h6b20_6574, 32'h7962_2d32, 32'h3320_646e, 32'h6170_7865};

    typedef logic [15:0][31:0] chacha_words_t;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    src_item_t   src_item;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_item_t   res_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow of the key and nonce registers as the predictor sees them
    logic [63:0] key_shadow [4];
    logic [63:0] nonce_lo_shadow;
    logic [31:0] nonce_hi_shadow;

    // Ciphertext blocks predicted at source acceptance, oldest first
    res_item_t   expected_ciphertext [$];

    bit          src_gaps_on;
    bit          res_stalls_on;
    int          stall_hold;
    int          error_count;
    int          blocks_sent;
    int          results_checked;
    int          cfg_writes;

    chacha20_keystream_xor_unit #(
        .DOUBLE_ROUNDS (ROUNDS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
        logic [63:0] dbl;
        dbl = {v, v} << n;
        return dbl[63:32];
    endfunction

    function automatic chacha_words_t quarter_mix(input chacha_words_t s,
                                                  input int a, input int b,
                                                  input int c, input int d);
        s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
        return s;
    endfunction

    // Data words and out words sit in the low 512 bits of both structs,
    // word 0 at the top, so word k is the slice [64*(7-k) +: 64].
    function automatic res_item_t predict_ciphertext(input src_item_t blk);
        chacha_words_t seed;
        chacha_words_t mixed;
        res_item_t     res;
        logic [63:0]   ks;
        logic [63:0]   keep;
        int unsigned   nbytes;
        int unsigned   left;
        for (int k = 0; k < 4; k++)
        begin
            seed[k]         = SIGMA_WORDS[32*k +: 32];
            seed[4 + 2*k]   = key_shadow[k][31:0];
            seed[5 + 2*k]   = key_shadow[k][63:32];
        end
        seed[12] = blk.block_counter;
        seed[13] = nonce_lo_shadow[31:0];
        seed[14] = nonce_lo_shadow[63:32];
        seed[15] = nonce_hi_shadow;

        mixed = seed;
        for (int r = 0; r < ROUNDS; r++)
        begin
            mixed = quarter_mix(mixed, 0, 4, 8, 12);
            mixed = quarter_mix(mixed, 1, 5, 9, 13);
            mixed = quarter_mix(mixed, 2, 6, 10, 14);
            mixed = quarter_mix(mixed, 3, 7, 11, 15);
            mixed = quarter_mix(mixed, 0, 5, 10, 15);
            mixed = quarter_mix(mixed, 1, 6, 11, 12);
            mixed = quarter_mix(mixed, 2, 7, 8, 13);
            mixed = quarter_mix(mixed, 3, 4, 9, 14);
        end

        // Counts above a full block saturate; zero blanks everything.
        nbytes = (blk.byte_count > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : blk.byte_count;
        res = '0;
        res.valid_bytes = nbytes[6:0];
        for (int k = 0; k < 8; k++)
        begin
            ks   = {mixed[2*k+1] + seed[2*k+1], mixed[2*k] + seed[2*k]};
            left = (nbytes > 8*k) ? nbytes - 8*k : 0;
            keep = (left >= 8) ? '1 : ((64'd1 << (8*left)) - 64'd1);
            res[64*(7-k) +: 64] = (blk[64*(7-k) +: 64] ^ ks) & keep;
        end
        return res;
    endfunction

    //------------------------------------------------------------------
    // Result side: stall generation and checking
    //------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_checker
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_checked++;
            if (expected_ciphertext.size() == 0)
            begin
                report_mismatch("unexpected result valid_bytes", '0,
                                64'(res_item.valid_bytes));
            end
            else
            begin
                want = expected_ciphertext.pop_front();
                if (res_item.valid_bytes !== want.valid_bytes)
                begin
                    report_mismatch("valid_bytes", 64'(want.valid_bytes),
                                    64'(res_item.valid_bytes));
                end
                for (int k = 0; k < 8; k++)
                begin
                    if (res_item[64*(7-k) +: 64] !== want[64*(7-k) +: 64])
                    begin
                        report_mismatch($sformatf("out_word_%0d", k),
                                        want[64*(7-k) +: 64], res_item[64*(7-k) +: 64]);
                    end
                end
            end
            // fresh stall length for the next transaction
            stall_hold = res_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
        end
        res_stall <= (stall_hold != 0);
        if (stall_hold != 0)
        begin
            stall_hold--;
        end
    end

    //------------------------------------------------------------------
    // Source and configuration drivers
    //------------------------------------------------------------------

    // Send one block; the expected ciphertext is queued at the accepting edge.
    task automatic send_block(input src_item_t blk);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= blk;
        do @(posedge clk); while (src_stall);
        expected_ciphertext.push_back(predict_ciphertext(blk));
        blocks_sent++;
    endtask

    // Every block yields exactly one result, so an empty queue means an idle pipe.
    task automatic drain_results();
        src_valid <= 1'b0;
        while (expected_ciphertext.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY_0_7:    key_shadow[0]   = value;
            REG_KEY_8_15:   key_shadow[1]   = value;
            REG_KEY_16_23:  key_shadow[2]   = value;
            REG_KEY_24_31:  key_shadow[3]   = value;
            REG_NONCE_0_7:  nonce_lo_shadow = value;
            REG_NONCE_8_11: nonce_hi_shadow = value[31:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic load_key_nonce(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] k2, input logic [63:0] k3,
                                  input logic [63:0] n0, input logic [63:0] n1);
        write_reg(REG_KEY_0_7, k0);
        write_reg(REG_KEY_8_15, k1);
        write_reg(REG_KEY_16_23, k2);
        write_reg(REG_KEY_24_31, k3);
        write_reg(REG_NONCE_0_7, n0);
        write_reg(REG_NONCE_8_11, n1);
    endtask

    function automatic src_item_t make_block(input logic [31:0] ctr, input logic [6:0] cnt,
                                             input logic [511:0] data);
        src_item_t blk;
        blk = '0;
        blk.block_counter = ctr;
        blk.byte_count    = cnt;
        blk[511:0]        = data;
        return blk;
    endfunction

    function automatic logic [511:0] random_data();
        logic [511:0] d;
        for (int k = 0; k < 16; k++)
        begin
            d[32*k +: 32] = $urandom;
        end
        return d;
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Key and nonce come out of reset as zero.
    task automatic test_reset_key();
        send_block(make_block(32'd0, 7'd64, '0));
        send_block(make_block(32'hffff_ffff, 7'd64, '1));
        send_block(make_block(32'd1, 7'd64, random_data()));
        drain_results();
    endtask

    // Block function vector from the ChaCha20 spec (key 00..1f, counter 1).
    task automatic test_known_answer();
        res_item_t ref_blk;
        load_key_nonce(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                       64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                       64'h4a00_0000_0900_0000, 64'd0);
        ref_blk = predict_ciphertext(make_block(32'd1, 7'd64, '0));
        if (ref_blk.out_word_0 !== 64'h1559_3bd1_e4e7_f110)
        begin
            report_mismatch("predictor out_word_0", 64'h1559_3bd1_e4e7_f110,
                            ref_blk.out_word_0);
        end
        if (ref_blk.out_word_1 !== 64'hc471_20a3_1fdd_0f50)
        begin
            report_mismatch("predictor out_word_1", 64'hc471_20a3_1fdd_0f50,
                            ref_blk.out_word_1);
        end
        send_block(make_block(32'd1, 7'd64, '0));
        send_block(make_block(32'd2, 7'd37, random_data()));
        drain_results();
    endtask

    // Masking around the first and last word edges, zero and over-range counts, counter wrap.
    task automatic test_byte_counts();
        logic [6:0] counts [10];
        logic [31:0] ctr;
        counts = '{7'd0, 7'd1, 7'd7, 7'd8, 7'd9, 7'd56, 7'd63, 7'd64, 7'd65, 7'd127};
        ctr = 32'hffff_fff8;
        foreach (counts[i])
        begin
            send_block(make_block(ctr, counts[i], '1));
            ctr++;
        end
        drain_results();
    endtask

    // All-ones and all-zero registers, plus writes to unused indexes.
    task automatic test_register_extremes();
        load_key_nonce('1, '1, '1, '1, '1, '1);
        send_block(make_block(32'hffff_ffff, 7'd64, random_data()));
        send_block(make_block(32'd0, 7'd33, random_data()));
        drain_results();
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, 64'(random_data()));
        send_block(make_block(32'h8000_0000, 7'd64, '0));
        drain_results();
        load_key_nonce('0, '0, '0, '0, '0, '0);
        send_block(make_block(32'h0000_0001, 7'd64, '1));
        drain_results();
    endtask

    // Mostly well-formed streams: full blocks under a running counter, with
    // partial tails, out-of-sequence counters and odd counts mixed in.
    task automatic test_random_stream(input int n_phases, input int per_phase);
        logic [31:0] ctr;
        logic [6:0]  cnt;
        int          pick;
        for (int p = 0; p < n_phases; p++)
        begin
            drain_results();
            pick = $urandom_range(0, 5);
            if (pick == 0)
            begin
                load_key_nonce('0, '0, '0, '0, '0, '0);
            end
            else if (pick == 1)
            begin
                load_key_nonce('1, '1, '1, '1, '1, '1);
            end
            else
            begin
                load_key_nonce({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
            end
            // cycle through every gap/stall combination, including none at all
            src_gaps_on   = p[0];
            res_stalls_on = p[1];
            ctr = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff - $urandom_range(0, 40)
                                              : $urandom;
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    ctr = $urandom;
                end
                pick = $urandom_range(0, 19);
                if (pick < 14)
                begin
                    cnt = 7'd64;
                end
                else if (pick < 18)
                begin
                    cnt = 7'($urandom_range(1, 63));
                end
                else if (pick == 18)
                begin
                    cnt = 7'd0;
                end
                else
                begin
                    cnt = 7'($urandom_range(65, 127));
                end
                send_block(make_block(ctr, cnt, random_data()));
                ctr++;
            end
        end
        drain_results();
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        src_valid       = 1'b0;
        src_item        = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        foreach (key_shadow[k])
        begin
            key_shadow[k] = '0;
        end
        nonce_lo_shadow = '0;
        nonce_hi_shadow = '0;
        src_gaps_on     = 1'b1;
        res_stalls_on   = 1'b1;
        stall_hold      = 0;
        error_count     = 0;
        blocks_sent     = 0;
        results_checked = 0;
        cfg_writes      = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_known_answer();
        test_byte_counts();
        test_register_extremes();
        test_random_stream(10, 185);

        repeat (LATENCY + 8) @(posedge clk);
        if (expected_ciphertext.size() != 0)
        begin
            report_mismatch("results still outstanding", 64'd0,
                            64'(expected_ciphertext.size()));
        end

        $display("Sent %0d blocks, checked %0d results, %0d register writes, %0d errors.",
                 blocks_sent, results_checked, cfg_writes, error_count);
        $display("Covered byte counts 0..127, counter wrap, zero/ones/random keys, stalls.");
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/cc20_pkg.sv
hdl/cc20_round_stage.sv
hdl/cc20_output_stage.sv
hdl/chacha20_keystream_xor_unit.sv
test/chacha20_keystream_xor_unit_tb.sv
